FILE: design/bpef_pkg.sv
`timescale 1ns / 1ps

package bpef_pkg;

    // sample and weight formats
    localparam int SAMPLE_WIDTH        = 24;
    localparam int ALPHA_FRACTION_BITS = 16;
    localparam int ALPHA_WIDTH         = ALPHA_FRACTION_BITS;
    localparam int PRESSURE_WIDTH      = 23;
    localparam int TEMP_WIDTH          = SAMPLE_WIDTH;
    localparam int ATTEMPT_WIDTH       = 4;
    localparam int SUM_WIDTH           = 27;
    localparam int BIAS_WIDTH          = 25;

    // filter arithmetic
    localparam int DIFF_WIDTH = SAMPLE_WIDTH + 1;
    localparam int PROD_WIDTH = DIFF_WIDTH + ALPHA_WIDTH + 1;

    // average divider
    localparam int DIVIDEND_WIDTH = SUM_WIDTH + 1;
    localparam int DIV_STEPS      = DIVIDEND_WIDTH;
    localparam int DIV_CNT_WIDTH  = $clog2(DIV_STEPS + 1);

    // stream packing
    localparam int TDATA_WIDTH = ((PRESSURE_WIDTH + TEMP_WIDTH + 7) / 8) * 8;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = PRESSURE_WIDTH;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRESSURE_ALPHA       = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TEMPERATURE_ALPHA    = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REFERENCE_PRESSURE   = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CALIBRATION_ATTEMPTS = CFG_INDEX_WIDTH'(3);

    localparam logic [ALPHA_WIDTH-1:0]    RST_PRESSURE_ALPHA       = ALPHA_WIDTH'(6554);
    localparam logic [ALPHA_WIDTH-1:0]    RST_TEMPERATURE_ALPHA    = ALPHA_WIDTH'(3277);
    localparam logic [PRESSURE_WIDTH-1:0] RST_REFERENCE_PRESSURE   = PRESSURE_WIDTH'(6432000);
    localparam logic [ATTEMPT_WIDTH-1:0]  RST_CALIBRATION_ATTEMPTS = ATTEMPT_WIDTH'(10);

    // result kinds
    localparam logic STATUS_MEASUREMENT = 1'b0;
    localparam logic STATUS_CAL_FAILED  = 1'b1;

    typedef struct packed {
        logic capture;
        logic seed;
        logic mul_p;
        logic mul_t;
        logic upd_t;
        logic cal_step;
        logic cal_fail;
        logic div_start;
        logic set_bias;
        logic load_meas;
        logic load_fail;
    } t_dp_cmd;

    typedef struct packed {
        logic ok;
        logic seeded;
        logic calibrating;
        logic cal_end;
        logic valid_zero;
        logic div_busy;
        logic div_done;
        logic out_busy;
    } t_dp_status;

endpackage

FILE: design/bpef_div.sv
`timescale 1ns / 1ps

module bpef_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [bpef_pkg::DIVIDEND_WIDTH-1:0]   i_dividend,
    input  logic [bpef_pkg::ATTEMPT_WIDTH-1:0]    i_divisor,
    output logic                                  o_busy,
    output logic                                  o_done,
    output logic [bpef_pkg::DIVIDEND_WIDTH-1:0]   o_quotient
);

    logic                                  r_busy;
    logic                                  r_done;
    logic [bpef_pkg::DIV_CNT_WIDTH-1:0]    r_cnt;
    logic [bpef_pkg::DIVIDEND_WIDTH-1:0]   r_quo;
    logic [bpef_pkg::ATTEMPT_WIDTH-1:0]    r_rem;

    logic [bpef_pkg::ATTEMPT_WIDTH:0]      trial;
    logic [bpef_pkg::ATTEMPT_WIDTH:0]      trial_sub;
    logic                                  q_bit;
    logic [bpef_pkg::ATTEMPT_WIDTH-1:0]    r_div;

    // one quotient bit per cycle, restoring
    assign trial     = {r_rem, r_quo[bpef_pkg::DIVIDEND_WIDTH-1]};
    assign trial_sub = trial - {1'b0, r_div};
    assign q_bit     = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= bpef_pkg::DIV_CNT_WIDTH'(bpef_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == bpef_pkg::DIV_CNT_WIDTH'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[bpef_pkg::DIVIDEND_WIDTH-2:0], q_bit};
            r_rem <= q_bit ? trial_sub[bpef_pkg::ATTEMPT_WIDTH-1:0]
                           : trial[bpef_pkg::ATTEMPT_WIDTH-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: design/bpef_dp.sv
`timescale 1ns / 1ps

module bpef_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  bpef_pkg::t_dp_cmd                       i_cmd,
    output bpef_pkg::t_dp_status                    o_status,
    input  logic                                    i_cfg_valid,
    input  logic [bpef_pkg::CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  logic [bpef_pkg::CFG_DATA_WIDTH-1:0]     i_cfg_data,
    input  logic                                    i_read_ok,
    input  logic [bpef_pkg::PRESSURE_WIDTH-1:0]     i_pressure_raw,
    input  logic signed [bpef_pkg::TEMP_WIDTH-1:0]  i_temperature_raw,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic                                    o_out_status,
    output logic [bpef_pkg::PRESSURE_WIDTH-1:0]     o_pressure_out,
    output logic signed [bpef_pkg::TEMP_WIDTH-1:0]  o_temperature_out
);

    localparam int SW = bpef_pkg::SAMPLE_WIDTH;
    localparam int PW = bpef_pkg::PRESSURE_WIDTH;
    localparam int OUT_SUM_WIDTH = bpef_pkg::BIAS_WIDTH + 1;
    localparam logic signed [bpef_pkg::PROD_WIDTH-1:0] PROD_HALF =
        bpef_pkg::PROD_WIDTH'(1) << (bpef_pkg::ALPHA_FRACTION_BITS - 1);
    localparam logic [PW-1:0] PRESSURE_MAX = {PW{1'b1}};

    // configuration
    logic [bpef_pkg::ALPHA_WIDTH-1:0]    r_p_alpha;
    logic [bpef_pkg::ALPHA_WIDTH-1:0]    r_t_alpha;
    logic [PW-1:0]                       r_ref;
    logic [bpef_pkg::ATTEMPT_WIDTH-1:0]  r_attempts;

    // captured item
    logic                                r_ok;
    logic signed [SW-1:0]                r_xp;
    logic signed [SW-1:0]                r_xt;

    // filter and calibration state
    logic                                r_seeded;
    logic signed [SW-1:0]                r_pf;
    logic signed [SW-1:0]                r_tf;
    logic signed [bpef_pkg::PROD_WIDTH-1:0] r_prod;
    logic                                r_calibrating;
    logic [bpef_pkg::ATTEMPT_WIDTH-1:0]  r_attempt_cnt;
    logic [bpef_pkg::ATTEMPT_WIDTH-1:0]  r_valid_cnt;
    logic [bpef_pkg::SUM_WIDTH-1:0]      r_sum;
    logic signed [bpef_pkg::BIAS_WIDTH-1:0] r_bias;

    // result register
    logic                                r_out_valid;
    logic                                r_out_status;
    logic [PW-1:0]                       r_out_p;
    logic signed [SW-1:0]                r_out_t;

    logic [bpef_pkg::ALPHA_WIDTH:0]             mul_a;
    logic signed [bpef_pkg::DIFF_WIDTH-1:0]     mul_diff;
    logic signed [bpef_pkg::PROD_WIDTH-1:0]     mul_prod;
    logic signed [bpef_pkg::PROD_WIDTH-1:0]     prod_rounded;
    logic signed [bpef_pkg::DIFF_WIDTH-1:0]     ema_inc;
    logic signed [bpef_pkg::DIFF_WIDTH-1:0]     ema_next;
    logic signed [bpef_pkg::DIFF_WIDTH-1:0]     base_f;
    logic [bpef_pkg::ATTEMPT_WIDTH-1:0]         limit;
    logic [bpef_pkg::DIVIDEND_WIDTH-1:0]        dividend;
    logic                                       div_busy;
    logic                                       div_done;
    logic [bpef_pkg::DIVIDEND_WIDTH-1:0]        quotient;
    logic signed [OUT_SUM_WIDTH-1:0]            corr;
    logic [PW-1:0]                              corr_sat;

    // shared multiplier: pressure weight in mul_p, temperature weight in mul_t
    assign mul_a = i_cmd.mul_t ? {1'b0, r_t_alpha} : {1'b0, r_p_alpha};
    assign mul_diff = i_cmd.mul_t ? ({r_xt[SW-1], r_xt} - {r_tf[SW-1], r_tf})
                                  : ({r_xp[SW-1], r_xp} - {r_pf[SW-1], r_pf});
    assign mul_prod = $signed(mul_a) * mul_diff;

    // f + round_half_up(a*(x-f) / one); the filter being updated sees r_prod
    assign prod_rounded = (r_prod + PROD_HALF) >>> bpef_pkg::ALPHA_FRACTION_BITS;
    assign ema_inc      = prod_rounded[bpef_pkg::DIFF_WIDTH-1:0];
    assign base_f       = i_cmd.upd_t ? {r_tf[SW-1], r_tf} : {r_pf[SW-1], r_pf};
    assign ema_next     = base_f + ema_inc;

    assign limit = (r_attempts == '0) ? bpef_pkg::ATTEMPT_WIDTH'(1) : r_attempts;
    assign dividend = {1'b0, r_sum}
                    + bpef_pkg::DIVIDEND_WIDTH'(r_valid_cnt >> 1);

    bpef_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_valid_cnt),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // corrected pressure, clamped to the unsigned field
    assign corr = {r_bias[bpef_pkg::BIAS_WIDTH-1], r_bias}
                + $signed({{(OUT_SUM_WIDTH-SW){1'b0}}, r_pf});
    always_comb begin
        if (corr < 0) begin
            corr_sat = '0;
        end else if (corr > $signed({{(OUT_SUM_WIDTH-PW){1'b0}}, PRESSURE_MAX})) begin
            corr_sat = PRESSURE_MAX;
        end else begin
            corr_sat = corr[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_alpha  <= bpef_pkg::RST_PRESSURE_ALPHA;
            r_t_alpha  <= bpef_pkg::RST_TEMPERATURE_ALPHA;
            r_ref      <= bpef_pkg::RST_REFERENCE_PRESSURE;
            r_attempts <= bpef_pkg::RST_CALIBRATION_ATTEMPTS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bpef_pkg::REG_PRESSURE_ALPHA: begin
                    r_p_alpha <= i_cfg_data[bpef_pkg::ALPHA_WIDTH-1:0];
                end
                bpef_pkg::REG_TEMPERATURE_ALPHA: begin
                    r_t_alpha <= i_cfg_data[bpef_pkg::ALPHA_WIDTH-1:0];
                end
                bpef_pkg::REG_REFERENCE_PRESSURE: begin
                    r_ref <= i_cfg_data[PW-1:0];
                end
                bpef_pkg::REG_CALIBRATION_ATTEMPTS: begin
                    r_attempts <= i_cfg_data[bpef_pkg::ATTEMPT_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ok <= i_read_ok;
            r_xp <= $signed({1'b0, i_pressure_raw});
            r_xt <= i_temperature_raw;
        end
        if (i_cmd.mul_p || i_cmd.mul_t) begin
            r_prod <= mul_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded      <= 1'b0;
            r_pf          <= '0;
            r_tf          <= '0;
            r_calibrating <= 1'b1;
            r_attempt_cnt <= '0;
            r_valid_cnt   <= '0;
            r_sum         <= '0;
            r_bias        <= '0;
        end else begin
            if (i_cmd.seed) begin
                r_pf     <= r_xp;
                r_tf     <= r_xt;
                r_seeded <= 1'b1;
            end
            if (i_cmd.mul_t) begin
                r_pf <= ema_next[SW-1:0];
            end
            if (i_cmd.upd_t) begin
                r_tf <= ema_next[SW-1:0];
            end
            if (i_cmd.cal_step) begin
                r_attempt_cnt <= r_attempt_cnt + 1'b1;
                if (r_ok) begin
                    r_valid_cnt <= r_valid_cnt + 1'b1;
                    r_sum <= r_sum
                           + {{(bpef_pkg::SUM_WIDTH-SW){1'b0}}, r_pf};
                end
            end
            if (i_cmd.cal_fail) begin
                r_attempt_cnt <= '0;
                r_sum         <= '0;
            end
            if (i_cmd.set_bias) begin
                r_bias <= $signed({{(bpef_pkg::BIAS_WIDTH-PW){1'b0}}, r_ref})
                        - $signed(quotient[bpef_pkg::BIAS_WIDTH-1:0]);
                r_calibrating <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_meas || i_cmd.load_fail) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_meas) begin
            r_out_status <= bpef_pkg::STATUS_MEASUREMENT;
            r_out_p      <= corr_sat;
            r_out_t      <= r_tf;
        end else if (i_cmd.load_fail) begin
            r_out_status <= bpef_pkg::STATUS_CAL_FAILED;
            r_out_p      <= '0;
            r_out_t      <= '0;
        end
    end

    always_comb begin
        o_status.ok          = r_ok;
        o_status.seeded      = r_seeded;
        o_status.calibrating = r_calibrating;
        o_status.cal_end     = (r_attempt_cnt >= limit) || (r_attempt_cnt == '0);
        o_status.valid_zero  = (r_valid_cnt == '0);
        o_status.div_busy    = div_busy;
        o_status.div_done    = div_done;
        o_status.out_busy    = r_out_valid && !i_out_ready;
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_status      = r_out_status;
    assign o_pressure_out    = r_out_p;
    assign o_temperature_out = r_out_t;

endmodule

FILE: design/bpef_ctrl.sv
`timescale 1ns / 1ps

module bpef_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  bpef_pkg::t_dp_status  i_status,
    output bpef_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILT,
        S_MULT,
        S_UPDT,
        S_CHK,
        S_CEND,
        S_DIV,
        S_EMIT_MEAS,
        S_EMIT_FAIL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;

    bpef_pkg::t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    cmd.capture = 1'b1;
                    n_state     = S_FILT;
                end
            end
            S_FILT: begin
                if (i_status.ok && i_status.seeded) begin
                    cmd.mul_p = 1'b1;
                    n_state   = S_MULT;
                end else begin
                    cmd.seed = i_status.ok;
                    n_state  = S_CHK;
                end
            end
            S_MULT: begin
                // pressure filter settles while temperature product forms
                cmd.mul_t = 1'b1;
                n_state   = S_UPDT;
            end
            S_UPDT: begin
                cmd.upd_t = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                if (i_status.calibrating) begin
                    cmd.cal_step = 1'b1;
                    n_state      = S_CEND;
                end else if (i_status.ok) begin
                    n_state = S_EMIT_MEAS;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CEND: begin
                if (!i_status.cal_end) begin
                    n_state = S_IDLE;
                end else if (i_status.valid_zero) begin
                    cmd.cal_fail = 1'b1;
                    n_state      = S_EMIT_FAIL;
                end else begin
                    cmd.div_start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    cmd.set_bias = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_EMIT_MEAS: begin
                if (!i_status.out_busy) begin
                    cmd.load_meas = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_EMIT_FAIL: begin
                if (!i_status.out_busy) begin
                    cmd.load_fail = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = cmd;

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> (r_state == S_IDLE))
        else $error("input ready outside idle");

    a_capture_then_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> (r_state == S_FILT))
        else $error("accepted beat not followed by filter step");

    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_meas || cmd.load_fail) |-> !i_status.out_busy)
        else $error("result loaded over an unsent beat");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !i_status.div_busy)
        else $error("divider restarted while busy");
`endif

endmodule

FILE: design/biased_pressure_ema_filter_top.sv
`timescale 1ns / 1ps

// Barometer smoother with calibrated offset. Each input beat carries read_ok in
// tuser and pressure (1/64 Pa) and Q8.16 temperature in tdata; two first-order
// low-pass filters share one 17x25 multiplier. A plain item passes the sequencer's
// filter, update and bookkeeping steps, one per cycle, from acceptance until ready
// returns; the item that closes calibration also waits on the one-bit-per-cycle
// average divider. A finished result sits
// in an output register, so a new beat is taken while it waits; a second result
// only stalls if the first one has not left. Calibration items give no beat,
// except a status 1 beat (zeros in tdata) when a whole phase saw no good read.
// Configuration writes are always ready and must only be issued while idle.
module biased_pressure_ema_filter_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // pressure_raw [22:0], temperature_raw [46:23], zero pad [47]
    input  logic [bpef_pkg::TDATA_WIDTH-1:0]        i_s_axis_tdata,
    // read_ok
    input  logic                                    i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // pressure_out [22:0], temperature_out [46:23], zero pad [47]
    output logic [bpef_pkg::TDATA_WIDTH-1:0]        o_m_axis_tdata,
    // status
    output logic                                    o_m_axis_tuser,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [bpef_pkg::CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  logic [bpef_pkg::CFG_DATA_WIDTH-1:0]     i_cfg_data
);

    localparam int PW = bpef_pkg::PRESSURE_WIDTH;
    localparam int TW = bpef_pkg::TEMP_WIDTH;
    localparam int PAD = bpef_pkg::TDATA_WIDTH - PW - TW;

    bpef_pkg::t_dp_cmd    cmd;
    bpef_pkg::t_dp_status status;

    logic                 out_status;
    logic [PW-1:0]        pressure_out;
    logic signed [TW-1:0] temperature_out;

    bpef_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bpef_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_read_ok         (i_s_axis_tuser),
        .i_pressure_raw    (i_s_axis_tdata[PW-1:0]),
        .i_temperature_raw ($signed(i_s_axis_tdata[PW+TW-1:PW])),
        .o_out_valid       (o_m_axis_tvalid),
        .i_out_ready       (i_m_axis_tready),
        .o_out_status      (out_status),
        .o_pressure_out    (pressure_out),
        .o_temperature_out (temperature_out)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tuser = out_status;
    assign o_m_axis_tdata = {{PAD{1'b0}}, temperature_out, pressure_out};

endmodule

FILE: tb/sv/bpef_checker.sv
`timescale 1ns / 1ps

module bpef_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    input  logic                                 i_s_tready,
    input  logic [bpef_pkg::TDATA_WIDTH-1:0]     i_s_tdata,
    input  logic                                 i_s_tuser,
    input  logic                                 i_m_tvalid,
    input  logic                                 i_m_tready,
    input  logic [bpef_pkg::TDATA_WIDTH-1:0]     i_m_tdata,
    input  logic                                 i_m_tuser,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [bpef_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [bpef_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output int                                   o_errors,
    output int                                   o_pending
);

    import bpef_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                      status;
        logic [PRESSURE_WIDTH-1:0] pressure;
        logic [TEMP_WIDTH-1:0]     temperature;
    } reading_t;

    logic [ALPHA_WIDTH-1:0]    p_alpha;
    logic [ALPHA_WIDTH-1:0]    t_alpha;
    logic [PRESSURE_WIDTH-1:0] ref_pressure;
    logic [ATTEMPT_WIDTH-1:0]  attempts_cfg;
    logic                      calibrating;
    logic                      seeded;
    logic [ATTEMPT_WIDTH-1:0]  attempt_cnt;
    logic [ATTEMPT_WIDTH-1:0]  valid_cnt;
    logic [SUM_WIDTH-1:0]      p_sum;
    longint                    p_filt;
    longint                    t_filt;
    longint                    p_bias;
    reading_t                  expected_readings[$];

    // exact first-order low-pass step, operands offset to unsigned, rounded half up
    function automatic longint ema_update(input longint prev, input longint sample,
                                          input logic [ALPHA_WIDTH-1:0] alpha);
        longint one;
        longint offs;
        longint acc;
        one  = longint'(1) << ALPHA_FRACTION_BITS;
        offs = longint'(1) << (SAMPLE_WIDTH - 1);
        acc  = longint'(alpha) * (sample + offs) + (one - longint'(alpha)) * (prev + offs)
             + (one >> 1);
        return (acc >> ALPHA_FRACTION_BITS) - offs;
    endfunction

    task automatic predict_reading(input logic ok, input logic [PRESSURE_WIDTH-1:0] praw,
                                   input logic [TEMP_WIDTH-1:0] traw);
        longint                   p;
        longint                   t;
        longint                   avg;
        longint                   level;
        logic [ATTEMPT_WIDTH-1:0] limit;
        reading_t                 r;
        p = longint'(praw);
        t = longint'($signed(traw));
        if (ok) begin
            if (!seeded) begin
                p_filt = p;
                t_filt = t;
                seeded = 1'b1;
            end else begin
                p_filt = ema_update(p_filt, p, p_alpha);
                t_filt = ema_update(t_filt, t, t_alpha);
            end
        end
        if (calibrating) begin
            limit = (attempts_cfg == '0) ? ATTEMPT_WIDTH'(1) : attempts_cfg;
            if (ok) begin
                p_sum     = p_sum + SUM_WIDTH'(p_filt);
                valid_cnt = valid_cnt + 1'b1;
            end
            attempt_cnt = attempt_cnt + 1'b1;
            if (attempt_cnt >= limit || attempt_cnt == '0) begin
                if (valid_cnt == '0) begin
                    // whole phase without a good read: report and start over
                    attempt_cnt   = '0;
                    p_sum         = '0;
                    r.status      = STATUS_CAL_FAILED;
                    r.pressure    = '0;
                    r.temperature = '0;
                    expected_readings.push_back(r);
                end else begin
                    avg = (longint'(p_sum) + longint'(valid_cnt >> 1)) / longint'(valid_cnt);
                    p_bias      = longint'(ref_pressure) - avg;
                    calibrating = 1'b0;
                end
            end
        end else if (ok) begin
            level = p_filt + p_bias;
            if (level < 0)
                level = 0;
            if (level > longint'({PRESSURE_WIDTH{1'b1}}))
                level = longint'({PRESSURE_WIDTH{1'b1}});
            r.status      = STATUS_MEASUREMENT;
            r.pressure    = PRESSURE_WIDTH'(level);
            r.temperature = TEMP_WIDTH'(t_filt);
            expected_readings.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        reading_t got;
        reading_t want;
        if (!i_rst_n) begin
            p_alpha      = RST_PRESSURE_ALPHA;
            t_alpha      = RST_TEMPERATURE_ALPHA;
            ref_pressure = RST_REFERENCE_PRESSURE;
            attempts_cfg = RST_CALIBRATION_ATTEMPTS;
            calibrating  = 1'b1;
            seeded       = 1'b0;
            attempt_cnt  = '0;
            valid_cnt    = '0;
            p_sum        = '0;
            p_filt       = 0;
            t_filt       = 0;
            p_bias       = 0;
            expected_readings.delete();
            o_errors     = 0;
        end else begin
            // results leave before the new beat's expectation is queued
            if (i_m_tvalid && i_m_tready) begin
                got.status      = i_m_tuser;
                got.pressure    = i_m_tdata[PRESSURE_WIDTH-1:0];
                got.temperature = i_m_tdata[PRESSURE_WIDTH +: TEMP_WIDTH];
                if (expected_readings.size() == 0) begin
                    o_errors++;
                    if (o_errors <= MAX_REPORTS)
                        $display("%0t: unexpected result beat: status %0d pressure %0d temp %0d",
                                 $realtime, got.status, got.pressure,
                                 $signed(got.temperature));
                end else begin
                    want = expected_readings.pop_front();
                    if (got.status !== want.status || got.pressure !== want.pressure ||
                        got.temperature !== want.temperature) begin
                        o_errors++;
                        if (o_errors <= MAX_REPORTS)
                            $display("%0t: mismatch: status %0d/%0d pressure %0d/%0d temp %0d/%0d (exp/act)",
                                     $realtime, want.status, got.status, want.pressure,
                                     got.pressure, $signed(want.temperature),
                                     $signed(got.temperature));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PRESSURE_ALPHA:       p_alpha      = i_cfg_data[ALPHA_WIDTH-1:0];
                    REG_TEMPERATURE_ALPHA:    t_alpha      = i_cfg_data[ALPHA_WIDTH-1:0];
                    REG_REFERENCE_PRESSURE:   ref_pressure = i_cfg_data[PRESSURE_WIDTH-1:0];
                    REG_CALIBRATION_ATTEMPTS: attempts_cfg = i_cfg_data[ATTEMPT_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                predict_reading(i_s_tuser, i_s_tdata[PRESSURE_WIDTH-1:0],
                                i_s_tdata[PRESSURE_WIDTH +: TEMP_WIDTH]);
        end
        o_pending = expected_readings.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import bpef_pkg::*;

    localparam int STALL_LIMIT      = 5000;
    localparam int LATENCY_GAP      = 48;
    localparam int OK_PER_PHASE     = 180;
    localparam int FIRST_UNUSED_REG = 4;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_s_axis_tvalid;
    logic                       o_s_axis_tready;
    logic [TDATA_WIDTH-1:0]     i_s_axis_tdata;
    logic                       i_s_axis_tuser;
    logic                       o_m_axis_tvalid;
    logic                       i_m_axis_tready;
    logic [TDATA_WIDTH-1:0]     o_m_axis_tdata;
    logic                       o_m_axis_tuser;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data;

    int check_errors;
    int backlog;
    int src_idle_pct;
    int snk_idle_pct;
    int stall_cycles;

    biased_pressure_ema_filter_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    bpef_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .i_m_tdata   (o_m_axis_tdata),
        .i_m_tuser   (o_m_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (check_errors),
        .o_pending   (backlog)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                     || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // all drive tasks start and end on a falling edge
    task automatic send_reading(input logic ok, input logic [PRESSURE_WIDTH-1:0] p,
                                input logic [TEMP_WIDTH-1:0] t);
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, t, p};
        i_s_axis_tuser  <= ok;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [CFG_DATA_WIDTH-1:0] val);
        i_s_axis_tvalid <= 1'b0;
        i_cfg_valid     <= 1'b1;
        i_cfg_index     <= idx;
        i_cfg_data      <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // wait for every expected result, then give a calibration close time to finish
    task automatic settle(input int extra);
        i_s_axis_tvalid <= 1'b0;
        i_cfg_valid     <= 1'b0;
        do @(negedge i_clk); while (backlog != 0);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic send_random_reading(output logic ok);
        logic [PRESSURE_WIDTH-1:0] p;
        logic [TEMP_WIDTH-1:0]     t;
        ok = ($urandom_range(99) < 85);
        case ($urandom_range(9))
            0:       p = '0;
            1:       p = '1;
            default: p = PRESSURE_WIDTH'($urandom);
        endcase
        case ($urandom_range(11))
            0:       t = {1'b1, {(TEMP_WIDTH-1){1'b0}}};
            1:       t = {1'b0, {(TEMP_WIDTH-1){1'b1}}};
            2:       t = '0;
            default: t = TEMP_WIDTH'($urandom);
        endcase
        send_reading(ok, p, t);
    endtask

    initial begin
        int   ok_sent;
        logic ok;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        src_idle_pct    = 9;
        snk_idle_pct    = 68;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero attempts acts as one; a failed read then fails the phase at once
        write_register(REG_CALIBRATION_ATTEMPTS, '0);
        write_register(REG_REFERENCE_PRESSURE, '0);
        send_reading(1'b0, '1, {1'b1, {(TEMP_WIDTH-1){1'b0}}});
        settle(LATENCY_GAP);

        // long phase, alpha extremes, seed on full-scale values
        write_register(REG_CALIBRATION_ATTEMPTS, CFG_DATA_WIDTH'(15));
        write_register(REG_PRESSURE_ALPHA, '0);
        write_register(REG_TEMPERATURE_ALPHA, CFG_DATA_WIDTH'(16'hFFFF));
        send_reading(1'b0, '0, {1'b0, {(TEMP_WIDTH-1){1'b1}}});
        send_reading(1'b1, '1, {1'b1, {(TEMP_WIDTH-1){1'b0}}});
        send_reading(1'b1, '0, {1'b0, {(TEMP_WIDTH-1){1'b1}}});
        send_reading(1'b1, PRESSURE_WIDTH'(23'h400000), '0);
        settle(LATENCY_GAP);

        // attempts lowered below the count so far: next beat closes calibration
        write_register(REG_CALIBRATION_ATTEMPTS, CFG_DATA_WIDTH'(2));
        write_register(REG_REFERENCE_PRESSURE, '1);
        write_register(REG_PRESSURE_ALPHA, CFG_DATA_WIDTH'(16'hFFFF));
        write_register(REG_TEMPERATURE_ALPHA, '0);
        send_reading(1'b1, PRESSURE_WIDTH'(23'h2AAAAA), TEMP_WIDTH'(24'h555555));
        send_reading(1'b0, '1, '1);
        send_reading(1'b1, '1, {1'b0, {(TEMP_WIDTH-1){1'b1}}});
        send_reading(1'b1, '0, {1'b1, {(TEMP_WIDTH-1){1'b0}}});
        send_reading(1'b1, PRESSURE_WIDTH'(23'h555555), TEMP_WIDTH'(24'hAAAAAA));
        send_reading(1'b1, PRESSURE_WIDTH'(1), '1);
        send_reading(1'b1, '0, '0);

        for (int ph = 0; ph < 3; ph++) begin
            settle(LATENCY_GAP);
            case (ph)
                0: begin
                    write_register(REG_PRESSURE_ALPHA, CFG_DATA_WIDTH'($urandom));
                    write_register(REG_TEMPERATURE_ALPHA, CFG_DATA_WIDTH'($urandom));
                    write_register(REG_REFERENCE_PRESSURE, CFG_DATA_WIDTH'($urandom));
                    write_register(REG_CALIBRATION_ATTEMPTS, CFG_DATA_WIDTH'(1));
                    write_register(CFG_INDEX_WIDTH'($urandom_range(255, FIRST_UNUSED_REG)),
                                   CFG_DATA_WIDTH'($urandom));
                end
                1: begin
                    src_idle_pct = 68;
                    snk_idle_pct = 9;
                    write_register(REG_PRESSURE_ALPHA, CFG_DATA_WIDTH'(1));
                    write_register(REG_TEMPERATURE_ALPHA, CFG_DATA_WIDTH'(16'hFFFF));
                    write_register(REG_REFERENCE_PRESSURE, '0);
                    write_register(REG_CALIBRATION_ATTEMPTS, CFG_DATA_WIDTH'(15));
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                    write_register(REG_PRESSURE_ALPHA, CFG_DATA_WIDTH'($urandom));
                    write_register(REG_TEMPERATURE_ALPHA, CFG_DATA_WIDTH'($urandom));
                    write_register(REG_REFERENCE_PRESSURE, '1);
                    write_register(REG_CALIBRATION_ATTEMPTS, CFG_DATA_WIDTH'($urandom));
                end
            endcase
            ok_sent = 0;
            // failed reads are dropped once calibrated, so only good ones count
            while (ok_sent < OK_PER_PHASE) begin
                send_random_reading(ok);
                if (ok)
                    ok_sent++;
            end
        end

        settle(LATENCY_GAP);
        if (check_errors == 0 && backlog == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
